@@ hw/rtl/spit_pkg.sv @@
// Shared constants and types for the segment pair intersection test.
`default_nettype none

package spit_pkg;

  // Default geometry of the datapath.
  localparam int unsigned COORD_WIDTH = 16;
  localparam int unsigned FRAC_BITS   = 8;

  // Width of the fixed point meeting point on the result side.
  localparam int unsigned MEET_WIDTH = 32;

  // Saturation limits of the meeting point.
  localparam logic [MEET_WIDTH-1:0] MEET_MAX = {1'b0, {(MEET_WIDTH-1){1'b1}}};
  localparam logic [MEET_WIDTH-1:0] MEET_MIN = {1'b1, {(MEET_WIDTH-1){1'b0}}};

  // Divider lanes: one for x, one for y.
  localparam int unsigned LANES  = 2;
  localparam int unsigned LANE_X = 0;
  localparam int unsigned LANE_Y = 1;

  // Slots of the bounding box limits, as carried through the pipeline.
  localparam int unsigned SPAN_X1_LO = 0;
  localparam int unsigned SPAN_X1_HI = 1;
  localparam int unsigned SPAN_X2_LO = 2;
  localparam int unsigned SPAN_X2_HI = 3;
  localparam int unsigned SPAN_Y1_LO = 4;
  localparam int unsigned SPAN_Y1_HI = 5;
  localparam int unsigned SPAN_Y2_LO = 6;
  localparam int unsigned SPAN_Y2_HI = 7;
  localparam int unsigned SPAN_COUNT = 8;

  // Per-item control that travels with the divider pipeline.
  typedef struct packed {
    logic             valid;
    logic             parallel;
    logic             hit;
    logic [LANES-1:0] ovf;
    logic [LANES-1:0] neg;
  } spit_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/spit_if.sv @@
// Valid/ready channel interfaces for segment pairs and meeting results.
`default_nettype none

interface spit_seg_if #(
  parameter int unsigned COORD_WIDTH = spit_pkg::COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] first_start_x;
  logic signed [COORD_WIDTH-1:0] first_start_y;
  logic signed [COORD_WIDTH-1:0] first_end_x;
  logic signed [COORD_WIDTH-1:0] first_end_y;
  logic signed [COORD_WIDTH-1:0] second_start_x;
  logic signed [COORD_WIDTH-1:0] second_start_y;
  logic signed [COORD_WIDTH-1:0] second_end_x;
  logic signed [COORD_WIDTH-1:0] second_end_y;

  modport source (
    output valid, first_start_x, first_start_y, first_end_x, first_end_y,
           second_start_x, second_start_y, second_end_x, second_end_y,
    input  ready
  );

  modport sink (
    input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
           second_start_x, second_start_y, second_end_x, second_end_y,
    output ready
  );
endinterface

interface spit_meet_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     hit;
  logic                                     parallel;
  logic signed [spit_pkg::MEET_WIDTH-1:0]   meet_x;
  logic signed [spit_pkg::MEET_WIDTH-1:0]   meet_y;
  logic                                     clipped;

  modport source (
    output valid, hit, parallel, meet_x, meet_y, clipped,
    input  ready
  );

  modport sink (
    input  valid, hit, parallel, meet_x, meet_y, clipped,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/segment_pair_intersection_test.sv @@
// Four product stages, two setup stages, one stage per quotient bit, one output register.
// Throughput: one segment pair per cycle unless a result is stalled; every stage holds a different pair.
// A stalled result freezes all stages together and input ready drops with it.
// Reset: rst_ni clears the valid bit of every stage; payload registers keep no reset.
`default_nettype none

module segment_pair_intersection_test #(
  parameter int unsigned COORD_WIDTH = spit_pkg::COORD_WIDTH,
  parameter int unsigned FRAC_BITS   = spit_pkg::FRAC_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  spit_seg_if.sink     seg_i,
  spit_meet_if.source  meet_o
);
  import spit_pkg::*;

  localparam int unsigned WW = 2 * COORD_WIDTH + 3;
  localparam int unsigned PW = 3 * COORD_WIDTH + 3;
  localparam int unsigned QW = MEET_WIDTH;

  // The whole pipeline advances unless a finished result is waiting.
  logic en;
  logic out_valid;

  assign en          = !out_valid || meet_o.ready;
  assign seg_i.ready = en;
  assign meet_o.valid = out_valid;

  // Product stages.
  logic                 f_valid;
  logic signed [PW-1:0] px, py;
  logic signed [WW-1:0] w;
  logic signed [PW-1:0] bound [SPAN_COUNT];

  spit_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (en),
    .valid_i          (seg_i.valid),
    .first_start_x_i  (seg_i.first_start_x),
    .first_start_y_i  (seg_i.first_start_y),
    .first_end_x_i    (seg_i.first_end_x),
    .first_end_y_i    (seg_i.first_end_y),
    .second_start_x_i (seg_i.second_start_x),
    .second_start_y_i (seg_i.second_start_y),
    .second_end_x_i   (seg_i.second_end_x),
    .second_end_y_i   (seg_i.second_end_y),
    .valid_o          (f_valid),
    .px_o             (px),
    .py_o             (py),
    .w_o              (w),
    .bound_o          (bound)
  );

  // Divider pipeline, one entry per stage boundary.
  spit_ctrl_t               ctrl_s [QW+1];
  logic [WW-1:0]            wmag_s [QW+1];
  logic [LANES-1:0][WW-1:0] rem_s  [QW+1];
  logic [LANES-1:0][QW-1:0] qn_s   [QW+1];

  spit_prep #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .px_i    (px),
    .py_i    (py),
    .w_i     (w),
    .bound_i (bound),
    .ctrl_o  (ctrl_s[0]),
    .wmag_o  (wmag_s[0]),
    .rem_o   (rem_s[0]),
    .qn_o    (qn_s[0])
  );

  for (genvar k = 0; k < QW; k++) begin : g_div
    spit_div_step #(
      .WMAG_WIDTH (WW)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctrl_i (ctrl_s[k]),
      .wmag_i (wmag_s[k]),
      .rem_i  (rem_s[k]),
      .qn_i   (qn_s[k]),
      .ctrl_o (ctrl_s[k+1]),
      .wmag_o (wmag_s[k+1]),
      .rem_o  (rem_s[k+1]),
      .qn_o   (qn_s[k+1])
    );
  end

  // Result register.
  spit_out #(
    .WMAG_WIDTH (WW)
  ) u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .ctrl_i     (ctrl_s[QW]),
    .rem_i      (rem_s[QW]),
    .qn_i       (qn_s[QW]),
    .valid_o    (out_valid),
    .hit_o      (meet_o.hit),
    .parallel_o (meet_o.parallel),
    .meet_x_o   (meet_o.meet_x),
    .meet_y_o   (meet_o.meet_y),
    .clipped_o  (meet_o.clipped)
  );

  // A parallel result carries no hit, no point and no saturation.
  a_parallel_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    meet_o.valid && meet_o.parallel |->
      !meet_o.hit && !meet_o.clipped && meet_o.meet_x == '0 && meet_o.meet_y == '0)
    else $error("parallel result carries hit, point or clip");

  // A saturated result shows a limit value on at least one axis.
  a_clip_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    meet_o.valid && meet_o.clipped |->
      (meet_o.meet_x == MEET_MAX || meet_o.meet_x == MEET_MIN ||
       meet_o.meet_y == MEET_MAX || meet_o.meet_y == MEET_MIN))
    else $error("clipped result without a saturated coordinate");

  // Input ready drops only behind a result that is waiting to be taken.
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seg_i.ready |-> meet_o.valid && !meet_o.ready)
    else $error("input stalled while the output side is free");

endmodule

`default_nettype wire

@@ hw/rtl/spit_front.sv @@
// Four product stages: supporting lines, homogeneous meeting point and box bounds.
`default_nettype none

module spit_front #(
  parameter int unsigned COORD_WIDTH = spit_pkg::COORD_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [COORD_WIDTH-1:0]     first_start_x_i,
  input  logic signed [COORD_WIDTH-1:0]     first_start_y_i,
  input  logic signed [COORD_WIDTH-1:0]     first_end_x_i,
  input  logic signed [COORD_WIDTH-1:0]     first_end_y_i,
  input  logic signed [COORD_WIDTH-1:0]     second_start_x_i,
  input  logic signed [COORD_WIDTH-1:0]     second_start_y_i,
  input  logic signed [COORD_WIDTH-1:0]     second_end_x_i,
  input  logic signed [COORD_WIDTH-1:0]     second_end_y_i,
  output logic                              valid_o,
  output logic signed [3*COORD_WIDTH+2:0]   px_o,
  output logic signed [3*COORD_WIDTH+2:0]   py_o,
  output logic signed [2*COORD_WIDTH+2:0]   w_o,
  output logic signed [3*COORD_WIDTH+2:0]   bound_o [spit_pkg::SPAN_COUNT]
);
  import spit_pkg::*;

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned DW  = CW + 1;       // line a and b terms
  localparam int unsigned CPW = 2 * CW;       // coordinate products
  localparam int unsigned LCW = 2 * CW + 1;   // line c terms
  localparam int unsigned WPW = 2 * CW + 2;   // weight products
  localparam int unsigned WW  = 2 * CW + 3;   // homogeneous weight
  localparam int unsigned PPW = 3 * CW + 2;   // meeting point products
  localparam int unsigned PW  = 3 * CW + 3;   // meeting point and bounds

  // Stage 1: line directions, endpoint cross terms and box limits.
  logic signed [DW-1:0]  la1_d, lb1_d, ma1_d, mb1_d;
  logic signed [DW-1:0]  la1_q, lb1_q, ma1_q, mb1_q;
  logic signed [CPW-1:0] pab1_d, pba1_d, pcd1_d, pdc1_d;
  logic signed [CPW-1:0] pab1_q, pba1_q, pcd1_q, pdc1_q;
  logic signed [CW-1:0]  span1_d [SPAN_COUNT];
  logic signed [CW-1:0]  span1_q [SPAN_COUNT];
  logic                  v1_q;

  assign la1_d  = DW'(first_start_y_i) - DW'(first_end_y_i);
  assign lb1_d  = DW'(first_end_x_i) - DW'(first_start_x_i);
  assign ma1_d  = DW'(second_start_y_i) - DW'(second_end_y_i);
  assign mb1_d  = DW'(second_end_x_i) - DW'(second_start_x_i);
  assign pab1_d = CPW'(first_start_x_i) * CPW'(first_end_y_i);
  assign pba1_d = CPW'(first_start_y_i) * CPW'(first_end_x_i);
  assign pcd1_d = CPW'(second_start_x_i) * CPW'(second_end_y_i);
  assign pdc1_d = CPW'(second_start_y_i) * CPW'(second_end_x_i);

  // Inclusive box limits of each segment on each axis.
  always_comb begin
    span1_d[SPAN_X1_LO] = (first_start_x_i < first_end_x_i) ? first_start_x_i : first_end_x_i;
    span1_d[SPAN_X1_HI] = (first_start_x_i < first_end_x_i) ? first_end_x_i : first_start_x_i;
    span1_d[SPAN_X2_LO] = (second_start_x_i < second_end_x_i) ? second_start_x_i
                                                              : second_end_x_i;
    span1_d[SPAN_X2_HI] = (second_start_x_i < second_end_x_i) ? second_end_x_i
                                                              : second_start_x_i;
    span1_d[SPAN_Y1_LO] = (first_start_y_i < first_end_y_i) ? first_start_y_i : first_end_y_i;
    span1_d[SPAN_Y1_HI] = (first_start_y_i < first_end_y_i) ? first_end_y_i : first_start_y_i;
    span1_d[SPAN_Y2_LO] = (second_start_y_i < second_end_y_i) ? second_start_y_i
                                                              : second_end_y_i;
    span1_d[SPAN_Y2_HI] = (second_start_y_i < second_end_y_i) ? second_end_y_i
                                                              : second_start_y_i;
  end

  // Stage 2: line offsets and the two weight products.
  logic signed [LCW-1:0] lc2_d, mc2_d, lc2_q, mc2_q;
  logic signed [WPW-1:0] wpa2_d, wpb2_d, wpa2_q, wpb2_q;
  logic signed [DW-1:0]  la2_q, lb2_q, ma2_q, mb2_q;
  logic signed [CW-1:0]  span2_q [SPAN_COUNT];
  logic                  v2_q;

  assign lc2_d  = LCW'(pab1_q) - LCW'(pba1_q);
  assign mc2_d  = LCW'(pcd1_q) - LCW'(pdc1_q);
  assign wpa2_d = WPW'(la1_q) * WPW'(mb1_q);
  assign wpb2_d = WPW'(lb1_q) * WPW'(ma1_q);

  // Stage 3: weight and the four meeting point products.
  logic signed [WW-1:0]  w3_d, w3_q;
  logic signed [PPW-1:0] lbmc3_d, lcmb3_d, lcma3_d, lamc3_d;
  logic signed [PPW-1:0] lbmc3_q, lcmb3_q, lcma3_q, lamc3_q;
  logic signed [CW-1:0]  span3_q [SPAN_COUNT];
  logic                  v3_q;

  assign w3_d    = WW'(wpa2_q) - WW'(wpb2_q);
  assign lbmc3_d = PPW'(lb2_q) * PPW'(mc2_q);
  assign lcmb3_d = PPW'(lc2_q) * PPW'(mb2_q);
  assign lcma3_d = PPW'(lc2_q) * PPW'(ma2_q);
  assign lamc3_d = PPW'(la2_q) * PPW'(mc2_q);

  // Stage 4: meeting point numerators and the box limits scaled by the weight.
  logic signed [PW-1:0] px4_d, py4_d, px4_q, py4_q;
  logic signed [PW-1:0] bound4_d [SPAN_COUNT];
  logic signed [PW-1:0] bound4_q [SPAN_COUNT];
  logic signed [WW-1:0] w4_q;
  logic                 v4_q;

  assign px4_d = PW'(lbmc3_q) - PW'(lcmb3_q);
  assign py4_d = PW'(lcma3_q) - PW'(lamc3_q);

  always_comb begin
    for (int k = 0; k < SPAN_COUNT; k++) begin
      bound4_d[k] = PW'(span3_q[k]) * PW'(w3_q);
    end
  end

  // Valid bits move with the data whenever the pipeline advances.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Payload registers of all four stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      la1_q   <= la1_d;
      lb1_q   <= lb1_d;
      ma1_q   <= ma1_d;
      mb1_q   <= mb1_d;
      pab1_q  <= pab1_d;
      pba1_q  <= pba1_d;
      pcd1_q  <= pcd1_d;
      pdc1_q  <= pdc1_d;
      span1_q <= span1_d;

      lc2_q   <= lc2_d;
      mc2_q   <= mc2_d;
      wpa2_q  <= wpa2_d;
      wpb2_q  <= wpb2_d;
      la2_q   <= la1_q;
      lb2_q   <= lb1_q;
      ma2_q   <= ma1_q;
      mb2_q   <= mb1_q;
      span2_q <= span1_q;

      w3_q    <= w3_d;
      lbmc3_q <= lbmc3_d;
      lcmb3_q <= lcmb3_d;
      lcma3_q <= lcma3_d;
      lamc3_q <= lamc3_d;
      span3_q <= span2_q;

      px4_q    <= px4_d;
      py4_q    <= py4_d;
      bound4_q <= bound4_d;
      w4_q     <= w3_q;
    end
  end

  assign valid_o = v4_q;
  assign px_o    = px4_q;
  assign py_o    = py4_q;
  assign w_o     = w4_q;
  assign bound_o = bound4_q;

endmodule

`default_nettype wire

@@ hw/rtl/spit_prep.sv @@
// Box test, sign split and divider setup: two stages ahead of the divide steps.
`default_nettype none

module spit_prep #(
  parameter int unsigned COORD_WIDTH = spit_pkg::COORD_WIDTH,
  parameter int unsigned FRAC_BITS   = spit_pkg::FRAC_BITS
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              en_i,
  input  logic                                              valid_i,
  input  logic signed [3*COORD_WIDTH+2:0]                   px_i,
  input  logic signed [3*COORD_WIDTH+2:0]                   py_i,
  input  logic signed [2*COORD_WIDTH+2:0]                   w_i,
  input  logic signed [3*COORD_WIDTH+2:0]                   bound_i [spit_pkg::SPAN_COUNT],
  output spit_pkg::spit_ctrl_t                              ctrl_o,
  output logic [2*COORD_WIDTH+2:0]                          wmag_o,
  output logic [spit_pkg::LANES-1:0][2*COORD_WIDTH+2:0]     rem_o,
  output logic [spit_pkg::LANES-1:0][spit_pkg::MEET_WIDTH-1:0] qn_o
);
  import spit_pkg::*;

  localparam int unsigned WW = 2 * COORD_WIDTH + 3;
  localparam int unsigned PW = 3 * COORD_WIDTH + 3;
  localparam int unsigned QW = MEET_WIDTH;
  localparam int unsigned NH = PW + FRAC_BITS;   // numerator bits above the quotient
  localparam int unsigned NW = NH + QW;          // whole scaled numerator

  // p / w lies in [lo, hi]; a negative weight flips both comparisons.
  function automatic logic in_span(input logic signed [PW-1:0] p,
                                   input logic signed [PW-1:0] lo_w,
                                   input logic signed [PW-1:0] hi_w,
                                   input logic                 wneg);
    logic ok;
    if (wneg) begin
      ok = (p <= lo_w) && (p >= hi_w);
    end else begin
      ok = (p >= lo_w) && (p <= hi_w);
    end
    return ok;
  endfunction

  // Stage 5: exact box test, magnitudes and result signs.
  logic                 wneg;
  logic                 wzero;
  logic                 hit5_d;
  logic [LANES-1:0]     neg5_d;
  logic [PW-1:0]        magx5_d, magy5_d, magx5_q, magy5_q;
  logic [WW-1:0]        wmag5_d, wmag5_q;
  spit_ctrl_t           ctrl5_d, ctrl5_q;

  assign wneg  = w_i[WW-1];
  assign wzero = (w_i == '0);

  assign hit5_d = !wzero
                  && in_span(px_i, bound_i[SPAN_X1_LO], bound_i[SPAN_X1_HI], wneg)
                  && in_span(px_i, bound_i[SPAN_X2_LO], bound_i[SPAN_X2_HI], wneg)
                  && in_span(py_i, bound_i[SPAN_Y1_LO], bound_i[SPAN_Y1_HI], wneg)
                  && in_span(py_i, bound_i[SPAN_Y2_LO], bound_i[SPAN_Y2_HI], wneg);

  // The quotient is negative when numerator and weight differ in sign.
  assign neg5_d[LANE_X] = (px_i != '0) && (px_i[PW-1] ^ wneg);
  assign neg5_d[LANE_Y] = (py_i != '0) && (py_i[PW-1] ^ wneg);

  assign magx5_d = px_i[PW-1] ? PW'(-px_i) : PW'(px_i);
  assign magy5_d = py_i[PW-1] ? PW'(-py_i) : PW'(py_i);
  assign wmag5_d = wneg ? WW'(-w_i) : WW'(w_i);

  always_comb begin
    ctrl5_d          = '0;
    ctrl5_d.valid    = valid_i;
    ctrl5_d.parallel = wzero;
    ctrl5_d.hit      = hit5_d;
    ctrl5_d.neg      = neg5_d;
  end

  // Stage 6: split the scaled numerator and catch quotients too large to form.
  logic [NW-1:0]        numx, numy;
  logic [NH-1:0]        hix, hiy;
  logic [LANES-1:0]     ovf6;
  spit_ctrl_t           ctrl6_d, ctrl6_q;
  logic [LANES-1:0][WW-1:0] rem6_d, rem6_q;
  logic [LANES-1:0][QW-1:0] qn6_d, qn6_q;
  logic [WW-1:0]        wmag6_q;

  assign numx = NW'(magx5_q) << FRAC_BITS;
  assign numy = NW'(magy5_q) << FRAC_BITS;
  assign hix  = numx[NW-1:QW];
  assign hiy  = numy[NW-1:QW];

  // A top part at or above the weight means the quotient needs more than QW bits.
  assign ovf6[LANE_X] = hix >= NH'(wmag5_q);
  assign ovf6[LANE_Y] = hiy >= NH'(wmag5_q);

  assign rem6_d[LANE_X] = ovf6[LANE_X] ? '0 : hix[WW-1:0];
  assign rem6_d[LANE_Y] = ovf6[LANE_Y] ? '0 : hiy[WW-1:0];
  assign qn6_d[LANE_X]  = numx[QW-1:0];
  assign qn6_d[LANE_Y]  = numy[QW-1:0];

  always_comb begin
    ctrl6_d     = ctrl5_q;
    ctrl6_d.ovf = ovf6;
  end

  // Control state of both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl5_q <= '0;
      ctrl6_q <= '0;
    end else if (en_i) begin
      ctrl5_q <= ctrl5_d;
      ctrl6_q <= ctrl6_d;
    end
  end

  // Payload of both stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      magx5_q <= magx5_d;
      magy5_q <= magy5_d;
      wmag5_q <= wmag5_d;
      rem6_q  <= rem6_d;
      qn6_q   <= qn6_d;
      wmag6_q <= wmag5_q;
    end
  end

  assign ctrl_o = ctrl6_q;
  assign wmag_o = wmag6_q;
  assign rem_o  = rem6_q;
  assign qn_o   = qn6_q;

endmodule

`default_nettype wire

@@ hw/rtl/spit_div_step.sv @@
// One restoring divide step for the x and y lanes, one quotient bit each.
`default_nettype none

module spit_div_step #(
  parameter int unsigned WMAG_WIDTH = 2 * spit_pkg::COORD_WIDTH + 3
) (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  en_i,
  input  spit_pkg::spit_ctrl_t                                  ctrl_i,
  input  logic [WMAG_WIDTH-1:0]                                 wmag_i,
  input  logic [spit_pkg::LANES-1:0][WMAG_WIDTH-1:0]            rem_i,
  input  logic [spit_pkg::LANES-1:0][spit_pkg::MEET_WIDTH-1:0]  qn_i,
  output spit_pkg::spit_ctrl_t                                  ctrl_o,
  output logic [WMAG_WIDTH-1:0]                                 wmag_o,
  output logic [spit_pkg::LANES-1:0][WMAG_WIDTH-1:0]            rem_o,
  output logic [spit_pkg::LANES-1:0][spit_pkg::MEET_WIDTH-1:0]  qn_o
);
  import spit_pkg::*;

  localparam int unsigned QW = MEET_WIDTH;

  // The quotient register also holds the numerator bits still to be shifted in.
  logic [WMAG_WIDTH:0]                   trial [LANES];
  logic [WMAG_WIDTH:0]                   diff  [LANES];
  logic [LANES-1:0][WMAG_WIDTH-1:0]      rem_d, rem_q;
  logic [LANES-1:0][QW-1:0]              qn_d, qn_q;
  logic [WMAG_WIDTH-1:0]                 wmag_q;
  spit_ctrl_t                            ctrl_q;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    assign trial[l] = {rem_i[l], qn_i[l][QW-1]};
    assign diff[l]  = trial[l] - {1'b0, wmag_i};
    // A borrow out of the top bit means the weight did not fit.
    assign rem_d[l] = diff[l][WMAG_WIDTH] ? trial[l][WMAG_WIDTH-1:0]
                                          : diff[l][WMAG_WIDTH-1:0];
    assign qn_d[l]  = {qn_i[l][QW-2:0], ~diff[l][WMAG_WIDTH]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      qn_q   <= qn_d;
      wmag_q <= wmag_i;
    end
  end

  assign ctrl_o = ctrl_q;
  assign wmag_o = wmag_q;
  assign rem_o  = rem_q;
  assign qn_o   = qn_q;

endmodule

`default_nettype wire

@@ hw/rtl/spit_out.sv @@
// Output register: floor rounding, sign, saturation and the parallel case.
`default_nettype none

module spit_out #(
  parameter int unsigned WMAG_WIDTH = 2 * spit_pkg::COORD_WIDTH + 3
) (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  en_i,
  input  spit_pkg::spit_ctrl_t                                  ctrl_i,
  input  logic [spit_pkg::LANES-1:0][WMAG_WIDTH-1:0]            rem_i,
  input  logic [spit_pkg::LANES-1:0][spit_pkg::MEET_WIDTH-1:0]  qn_i,
  output logic                                                  valid_o,
  output logic                                                  hit_o,
  output logic                                                  parallel_o,
  output logic signed [spit_pkg::MEET_WIDTH-1:0]                meet_x_o,
  output logic signed [spit_pkg::MEET_WIDTH-1:0]                meet_y_o,
  output logic                                                  clipped_o
);
  import spit_pkg::*;

  localparam int unsigned QW = MEET_WIDTH;

  logic [QW-1:0]    val_d [LANES];
  logic [LANES-1:0] clip_d;

  // Per lane: positive quotients floor by truncation, negative ones round away.
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic          inexact;
    logic [QW:0]   qq;
    logic          neg_big;
    logic          clip;

    assign inexact = |rem_i[l];
    assign qq      = {1'b0, qn_i[l]} + (QW + 1)'(inexact);
    // A negative magnitude above 2^(QW-1) no longer fits.
    assign neg_big = qq[QW] | (qq[QW-1] & (|qq[QW-2:0]));
    assign clip    = ctrl_i.ovf[l] | (ctrl_i.neg[l] ? neg_big : qn_i[l][QW-1]);

    always_comb begin
      if (ctrl_i.parallel) begin
        val_d[l] = '0;
      end else if (ctrl_i.neg[l]) begin
        val_d[l] = clip ? MEET_MIN : QW'(-qq[QW-1:0]);
      end else begin
        val_d[l] = clip ? MEET_MAX : qn_i[l];
      end
    end

    assign clip_d[l] = clip & ~ctrl_i.parallel;
  end

  logic                   valid_q;
  logic                   hit_q, parallel_q, clipped_q;
  logic signed [QW-1:0]   meet_x_q, meet_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q      <= ctrl_i.hit;
      parallel_q <= ctrl_i.parallel;
      meet_x_q   <= val_d[LANE_X];
      meet_y_q   <= val_d[LANE_Y];
      clipped_q  <= |clip_d;
    end
  end

  assign valid_o    = valid_q;
  assign hit_o      = hit_q;
  assign parallel_o = parallel_q;
  assign meet_x_o   = meet_x_q;
  assign meet_y_o   = meet_y_q;
  assign clipped_o  = clipped_q;

endmodule

`default_nettype wire

@@ test/tb_segment_pair_intersection_test.sv @@
// Self-checking testbench for the segment pair intersection test block.
`timescale 1ns / 100ps

typedef logic signed [spit_pkg::COORD_WIDTH-1:0] coord_t;
typedef logic signed [spit_pkg::MEET_WIDTH-1:0]  meet_coord_t;

// One segment pair as it crosses the input channel.
typedef struct {
  coord_t first_start_x;
  coord_t first_start_y;
  coord_t first_end_x;
  coord_t first_end_y;
  coord_t second_start_x;
  coord_t second_start_y;
  coord_t second_end_x;
  coord_t second_end_y;
} seg_pair_t;

// One meeting result as it crosses the output channel.
typedef struct {
  logic        hit;
  logic        parallel;
  meet_coord_t meet_x;
  meet_coord_t meet_y;
  logic        clipped;
} meeting_t;

// Predicts the meeting of each accepted pair and checks results in order.
class meeting_ledger;
  meeting_t    pending_meetings[$];
  int unsigned failures;
  int unsigned reported;

  function int unsigned pending();
    return pending_meetings.size();
  endfunction

  // Inclusive test of p/w against the span of a and b, with w positive.
  static function bit covers(longint p, longint a, longint b, longint w);
    longint lo;
    longint hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return (p >= lo * w) && (p <= hi * w);
  endfunction

  // Floored fixed point quotient, saturated to the meeting coordinate range.
  static function meet_coord_t fixed_point(longint num, longint den, inout bit clip);
    longint scaled;
    longint quo;
    longint top;
    longint bottom;
    scaled = num * (longint'(1) << spit_pkg::FRAC_BITS);
    quo    = scaled / den;
    // Division truncates toward zero, so pull negative inexact quotients down.
    if (scaled < 0 && (scaled % den) != 0) begin
      quo = quo - 1;
    end
    top    = longint'($signed(spit_pkg::MEET_MAX));
    bottom = longint'($signed(spit_pkg::MEET_MIN));
    if (quo > top) begin
      clip = 1'b1;
      return spit_pkg::MEET_MAX;
    end
    if (quo < bottom) begin
      clip = 1'b1;
      return spit_pkg::MEET_MIN;
    end
    return meet_coord_t'(quo);
  endfunction

  // Homogeneous line through each segment, then the meeting of the two lines.
  function meeting_t meeting_of(seg_pair_t p);
    meeting_t m;
    longint   ax, ay, bx, by, cx, cy, dx, dy;
    longint   la, lb, lc, ma, mb, mc;
    longint   px, py, w;
    bit       clip;
    ax = longint'(p.first_start_x);
    ay = longint'(p.first_start_y);
    bx = longint'(p.first_end_x);
    by = longint'(p.first_end_y);
    cx = longint'(p.second_start_x);
    cy = longint'(p.second_start_y);
    dx = longint'(p.second_end_x);
    dy = longint'(p.second_end_y);
    la = ay - by;
    lb = bx - ax;
    lc = ax * by - ay * bx;
    ma = cy - dy;
    mb = dx - cx;
    mc = cx * dy - cy * dx;
    px = lb * mc - lc * mb;
    py = lc * ma - la * mc;
    w  = la * mb - lb * ma;
    m.hit      = 1'b0;
    m.parallel = 1'b0;
    m.meet_x   = '0;
    m.meet_y   = '0;
    m.clipped  = 1'b0;
    // Zero weight covers parallel, collinear and point-sized segments.
    if (w == 0) begin
      m.parallel = 1'b1;
      return m;
    end
    if (w < 0) begin
      px = -px;
      py = -py;
      w  = -w;
    end
    m.hit = covers(px, ax, bx, w) && covers(px, cx, dx, w) &&
            covers(py, ay, by, w) && covers(py, cy, dy, w);
    clip      = 1'b0;
    m.meet_x  = fixed_point(px, w, clip);
    m.meet_y  = fixed_point(py, w, clip);
    m.clipped = clip;
    return m;
  endfunction

  function void note_pair(seg_pair_t p);
    pending_meetings.push_back(meeting_of(p));
  endfunction

  function void check_meeting(meeting_t got);
    meeting_t want;
    if (pending_meetings.size() == 0) begin
      failures++;
      if (reported < 10) begin
        reported++;
        $display("%0t: result with nothing pending: hit=%0b parallel=%0b x=%0d y=%0d clipped=%0b",
                 $realtime, got.hit, got.parallel, got.meet_x, got.meet_y, got.clipped);
      end
      return;
    end
    want = pending_meetings.pop_front();
    if (got.hit !== want.hit || got.parallel !== want.parallel ||
        got.meet_x !== want.meet_x || got.meet_y !== want.meet_y ||
        got.clipped !== want.clipped) begin
      failures++;
      if (reported < 10) begin
        reported++;
        $display("%0t: meeting mismatch", $realtime);
        $display("  expected hit=%0b parallel=%0b x=%0d y=%0d clipped=%0b",
                 want.hit, want.parallel, want.meet_x, want.meet_y, want.clipped);
        $display("  actual   hit=%0b parallel=%0b x=%0d y=%0d clipped=%0b",
                 got.hit, got.parallel, got.meet_x, got.meet_y, got.clipped);
      end
    end
  endfunction
endclass

module tb_segment_pair_intersection_test;

  localparam int RANDOM_PAIRS = 1000;
  localparam int DRAIN_CYCLES = spit_pkg::MEET_WIDTH + 24;

  logic clk;
  logic rst_n;
  bit   sender_burst;

  spit_seg_if #(.COORD_WIDTH(spit_pkg::COORD_WIDTH)) seg_bus ();
  spit_meet_if meet_bus ();

  segment_pair_intersection_test uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .seg_i  (seg_bus),
    .meet_o (meet_bus)
  );

  meeting_ledger ledger = new();

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic seg_pair_t make_pair(int ax, int ay, int bx, int by,
                                          int cx, int cy, int dx, int dy);
    seg_pair_t p;
    p.first_start_x  = coord_t'(ax);
    p.first_start_y  = coord_t'(ay);
    p.first_end_x    = coord_t'(bx);
    p.first_end_y    = coord_t'(by);
    p.second_start_x = coord_t'(cx);
    p.second_start_y = coord_t'(cy);
    p.second_end_x   = coord_t'(dx);
    p.second_end_y   = coord_t'(dy);
    return p;
  endfunction

  function automatic coord_t coord_near(int span);
    return coord_t'($urandom_range(0, 2 * span)) - coord_t'(span);
  endfunction

  function automatic coord_t coord_any();
    return coord_t'($urandom);
  endfunction

  // Random pair: full range, small boxes, near parallel, parallel or point,
  // and pairs that share an endpoint.
  function automatic seg_pair_t random_pair();
    seg_pair_t p;
    coord_t    ox;
    coord_t    oy;
    p.first_start_x = coord_any();
    p.first_start_y = coord_any();
    p.first_end_x   = coord_any();
    p.first_end_y   = coord_any();
    p.second_start_x = coord_any();
    p.second_start_y = coord_any();
    p.second_end_x   = coord_any();
    p.second_end_y   = coord_any();
    ox = coord_near(300);
    oy = coord_near(300);
    case ($urandom_range(0, 9))
      4, 5, 6: begin
        p.first_start_x  = coord_near(64);
        p.first_start_y  = coord_near(64);
        p.first_end_x    = coord_near(64);
        p.first_end_y    = coord_near(64);
        p.second_start_x = coord_near(64);
        p.second_start_y = coord_near(64);
        p.second_end_x   = coord_near(64);
        p.second_end_y   = coord_near(64);
      end
      7: begin
        p.second_start_x = p.first_start_x + ox;
        p.second_start_y = p.first_start_y + oy;
        p.second_end_x   = p.first_end_x + ox + coord_near(1);
        p.second_end_y   = p.first_end_y + oy + coord_near(1);
      end
      8: begin
        if ($urandom_range(0, 2) == 0) begin
          p.first_end_x = p.first_start_x;
          p.first_end_y = p.first_start_y;
        end
        p.second_start_x = p.first_start_x + ox;
        p.second_start_y = p.first_start_y + oy;
        p.second_end_x   = p.first_end_x + ox;
        p.second_end_y   = p.first_end_y + oy;
      end
      9: begin
        p.second_start_x = p.first_end_x;
        p.second_start_y = p.first_end_y;
      end
      default: begin
      end
    endcase
    return p;
  endfunction

  // Present one pair after a random gap and hold it until the transfer.
  task automatic send_pair(input seg_pair_t p);
    int gap;
    if ($urandom_range(0, 39) == 0) begin
      sender_burst = !sender_burst;
    end
    gap = sender_burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      seg_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    seg_bus.first_start_x  <= p.first_start_x;
    seg_bus.first_start_y  <= p.first_start_y;
    seg_bus.first_end_x    <= p.first_end_x;
    seg_bus.first_end_y    <= p.first_end_y;
    seg_bus.second_start_x <= p.second_start_x;
    seg_bus.second_start_y <= p.second_start_y;
    seg_bus.second_end_x   <= p.second_end_x;
    seg_bus.second_end_y   <= p.second_end_y;
    seg_bus.valid          <= 1'b1;
    do @(posedge clk); while (seg_bus.ready !== 1'b1);
    ledger.note_pair(p);
  endtask

  task automatic wait_for_drain();
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  // Result side: random stalls, then accept and check one result.
  initial begin
    int       stall;
    bit       burst;
    meeting_t got;
    burst = 1'b0;
    meet_bus.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) begin
        burst = !burst;
      end
      stall = burst ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        meet_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      meet_bus.ready <= 1'b1;
      do @(posedge clk); while (meet_bus.valid !== 1'b1);
      got.hit      = meet_bus.hit;
      got.parallel = meet_bus.parallel;
      got.meet_x   = meet_bus.meet_x;
      got.meet_y   = meet_bus.meet_y;
      got.clipped  = meet_bus.clipped;
      ledger.check_meeting(got);
    end
  end

  // Reset, directed pairs, random pairs, then drain and report.
  initial begin
    seg_pair_t directed_pairs[$];
    rst_n                  <= 1'b0;
    seg_bus.valid          <= 1'b0;
    seg_bus.first_start_x  <= '0;
    seg_bus.first_start_y  <= '0;
    seg_bus.first_end_x    <= '0;
    seg_bus.first_end_y    <= '0;
    seg_bus.second_start_x <= '0;
    seg_bus.second_start_y <= '0;
    seg_bus.second_end_x   <= '0;
    seg_bus.second_end_y   <= '0;

    // Crossing at the origin, and segments that only touch at an endpoint.
    directed_pairs.push_back(make_pair(-10, -10, 10, 10, -10, 10, 10, -10));
    directed_pairs.push_back(make_pair(0, 0, 4, 4, 4, 4, 8, 0));
    // Lines meet at a fractional point beyond both segments.
    directed_pairs.push_back(make_pair(0, 0, 1, 1, 5, 0, 6, -1));
    // Negative fractional point, which floors away from zero.
    directed_pairs.push_back(make_pair(0, 0, -2, -1, -2, 0, 0, -2));
    // Parallel, overlapping collinear, one point-sized and two point-sized.
    directed_pairs.push_back(make_pair(0, 0, 10, 0, 0, 5, 10, 5));
    directed_pairs.push_back(make_pair(0, 0, 10, 10, 5, 5, 15, 15));
    directed_pairs.push_back(make_pair(3, 3, 3, 3, 0, 0, 6, 6));
    directed_pairs.push_back(make_pair(7, -7, 7, -7, -2, 9, -2, 9));
    // All fields at the top, then all at the bottom of the range.
    directed_pairs.push_back(make_pair(32767, 32767, 32767, 32767,
                                       32767, 32767, 32767, 32767));
    directed_pairs.push_back(make_pair(-32768, -32768, -32768, -32768,
                                       -32768, -32768, -32768, -32768));
    // Full-range diagonals that cross.
    directed_pairs.push_back(make_pair(-32768, -32768, 32767, 32767,
                                       -32768, 32767, 32767, -32768));
    // Nearly parallel lines that meet far out, saturating high and low.
    directed_pairs.push_back(make_pair(-32768, 0, 32767, 1, -32768, 200, 32767, 200));
    directed_pairs.push_back(make_pair(-32768, 0, 32767, 1, -32768, -200, 32767, -200));
    // Vertical against horizontal across the whole range, then an antidiagonal against a nearly level line.
    directed_pairs.push_back(make_pair(5, -32768, 5, 32767, -32768, 7, 32767, 7));
    directed_pairs.push_back(make_pair(32767, -32768, -32768, 32767,
                                       -32768, -32768, 32767, -32767));
    // Meeting point just past the end of the first segment.
    directed_pairs.push_back(make_pair(0, 0, 10, 0, 11, -5, 11, 5));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_pairs[i]) begin
      send_pair(directed_pairs[i]);
    end
    // Hold off the sender until the pipeline is empty.
    seg_bus.valid <= 1'b0;
    wait_for_drain();

    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      if (n == RANDOM_PAIRS / 2) begin
        seg_bus.valid <= 1'b0;
        wait_for_drain();
      end
      send_pair(random_pair());
    end
    seg_bus.valid <= 1'b0;

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (ledger.failures == 0 && ledger.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/spit_pkg.sv
hw/rtl/spit_if.sv
hw/rtl/spit_front.sv
hw/rtl/spit_prep.sv
hw/rtl/spit_div_step.sv
hw/rtl/spit_out.sv
hw/rtl/segment_pair_intersection_test.sv
test/tb_segment_pair_intersection_test.sv
